/* hdl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. Define ASSERT_OFF to compile them out.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* hdl/mrtu_pkg.sv */
// ---------------------------------------------------------------------------
// mrtu_pkg
// Constants, types and the CRC-16 byte update for the RTU frame checker.
// ---------------------------------------------------------------------------
package mrtu_pkg;

   // Longest frame accepted, in bytes, CRC included
   localparam int MAX_FRAME_LEN = 256;

   // CRC-16 (reflected) constants
   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;

   // Fixed frame lengths
   localparam logic [8:0] LEN_EXCEPTION = 9'd5;
   localparam logic [8:0] LEN_FIXED     = 9'd8;
   // Overhead added to a byte count: header plus CRC
   localparam logic [8:0] LEN_RSP_HDR   = 9'd5;
   localparam logic [8:0] LEN_REQ_HDR   = 9'd9;
   // Address and CRC bytes excluded from the PDU length
   localparam logic [8:0] LEN_OVERHEAD  = 9'd3;

   // Byte-count positions
   localparam logic [8:0] POS_UNIT      = 9'd0;
   localparam logic [8:0] POS_FUNC      = 9'd1;
   localparam logic [8:0] POS_RSP_COUNT = 9'd2;
   localparam logic [8:0] POS_REQ_COUNT = 9'd6;

   // Function codes
   localparam logic [7:0] FC_READ_COILS    = 8'd1;
   localparam logic [7:0] FC_READ_INPUT    = 8'd4;
   localparam logic [7:0] FC_WRITE_COIL    = 8'd5;
   localparam logic [7:0] FC_WRITE_REG     = 8'd6;
   localparam logic [7:0] FC_WRITE_COILS   = 8'd15;
   localparam logic [7:0] FC_WRITE_REGS    = 8'd16;

   typedef enum logic [1:0] {
      STATUS_INCOMPLETE = 2'd0,
      STATUS_GOOD       = 2'd1,
      STATUS_BAD        = 2'd2
   } frame_status_type;

   // Advance the CRC over one byte, LSB first
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                              input logic [7:0]  data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

/* hdl/modbus_rtu_frame_checker.sv */
// ---------------------------------------------------------------------------
// modbus_rtu_frame_checker
// Frames RTU messages byte by byte and checks the trailing CRC-16.
// ---------------------------------------------------------------------------
// Takes one received byte per word and returns one word per byte: the byte,
// its position in the frame, a PDU flag and the frame status (incomplete,
// good, bad). A good status also carries the unit address and PDU length.
// The block accepts a byte every clock cycle while req_stall is low and
// answers in the next cycle; the path that sets this is the combinational
// CRC byte update and length decode from input port to result register.
// csr_wr_data sets slave mode (1: requests, 0: responses); it is sampled at
// each length decision. A good or bad frame rearms the parser on its own.

`include "assert_macros.svh"

module modbus_rtu_frame_checker #(
   parameter int MAX_FRAME_LEN = mrtu_pkg::MAX_FRAME_LEN
) (
   input  logic       clock,
   input  logic       reset,
   // configuration
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,
   // received bytes
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   // results
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_data_byte,
   output logic [7:0] rsp_byte_position,
   output logic       rsp_is_pdu_byte,
   output logic [1:0] rsp_frame_status,
   output logic [7:0] rsp_frame_unit,
   output logic [7:0] rsp_pdu_length
);

   import mrtu_pkg::*;

   // Configuration
   logic             slave_mode_ff;

   // Frame state
   logic [8:0]       byte_count_ff, byte_count_in;
   logic [8:0]       exp_len_ff, exp_len_in;
   logic [15:0]      crc_ff, crc_in;
   logic [7:0]       unit_ff, unit_in;
   logic [7:0]       crc_low_ff, crc_low_in;

   // Result register
   logic             rsp_valid_ff;
   logic [7:0]       data_ff;
   logic [7:0]       pos_ff;
   logic             pdu_ff, pdu_in;
   frame_status_type status_ff, status_in;
   logic [7:0]       frame_unit_ff, frame_unit_in;
   logic [7:0]       pdu_len_ff, pdu_len_in;

   logic             accept;
   logic             done;
   logic [9:0]       pos_p1, pos_p2, exp_wide;
   logic [7:0]       b;

   // Stall only while a finished word is held back
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign b         = req_rx_byte;

   // Decode one byte against the frame state
   always_comb begin
      unit_in       = unit_ff;
      exp_len_in    = exp_len_ff;
      crc_in        = crc_ff;
      crc_low_in    = crc_low_ff;
      status_in     = STATUS_INCOMPLETE;
      frame_unit_in = 8'd0;
      pdu_len_in    = 8'd0;

      // Capture address, function code and byte count
      if (byte_count_ff == POS_UNIT) begin
         unit_in = b;
      end else if (byte_count_ff == POS_FUNC) begin
         if (!slave_mode_ff) begin
            priority if (b[7]) begin
               exp_len_in = LEN_EXCEPTION;
            end else if (b >= FC_READ_COILS && b <= FC_READ_INPUT) begin
               exp_len_in = 9'd0;
            end else if (b == FC_WRITE_COIL || b == FC_WRITE_REG ||
                         b == FC_WRITE_COILS || b == FC_WRITE_REGS) begin
               exp_len_in = LEN_FIXED;
            end else begin
               status_in = STATUS_BAD;
            end
         end else begin
            priority if (b >= FC_READ_COILS && b <= FC_WRITE_REG) begin
               exp_len_in = LEN_FIXED;
            end else if (b == FC_WRITE_COILS || b == FC_WRITE_REGS) begin
               exp_len_in = 9'd0;
            end else begin
               status_in = STATUS_BAD;
            end
         end
      end else if (exp_len_ff == 9'd0) begin
         if (!slave_mode_ff && byte_count_ff == POS_RSP_COUNT) begin
            exp_len_in = {1'b0, b} + LEN_RSP_HDR;
         end else if (slave_mode_ff && byte_count_ff == POS_REQ_COUNT) begin
            exp_len_in = {1'b0, b} + LEN_REQ_HDR;
         end
      end

      // Drop frames longer than the maximum
      if (status_in == STATUS_INCOMPLETE && byte_count_ff != POS_UNIT &&
          exp_len_in > 9'(MAX_FRAME_LEN)) begin
         status_in = STATUS_BAD;
      end

      pos_p1   = {1'b0, byte_count_ff} + 10'd1;
      pos_p2   = {1'b0, byte_count_ff} + 10'd2;
      exp_wide = {1'b0, exp_len_in};

      // Hold the CRC low byte, check on the high byte, else advance the CRC
      if (status_in == STATUS_INCOMPLETE) begin
         if (exp_len_in != 9'd0 && pos_p2 == exp_wide) begin
            crc_low_in = b;
         end else if (exp_len_in != 9'd0 && pos_p1 == exp_wide) begin
            if (crc_ff == {b, crc_low_ff}) begin
               status_in     = STATUS_GOOD;
               frame_unit_in = unit_ff;
               pdu_len_in    = 8'(exp_len_in - LEN_OVERHEAD);
            end else begin
               status_in = STATUS_BAD;
            end
         end else begin
            crc_in = crc16_byte(crc_ff, b);
         end
      end

      // PDU flag
      if (byte_count_ff == POS_UNIT) begin
         pdu_in = 1'b0;
      end else if (status_in == STATUS_BAD || exp_len_in == 9'd0) begin
         pdu_in = 1'b1;
      end else begin
         pdu_in = (pos_p2 < exp_wide);
      end

      done          = (status_in != STATUS_INCOMPLETE);
      byte_count_in = byte_count_ff + 9'd1;
   end

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         slave_mode_ff <= 1'b0;
      end else if (csr_wr_en) begin
         slave_mode_ff <= csr_wr_data;
      end
   end

   // Frame state: advance on each byte, rearm after a finished frame
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= 9'd0;
         exp_len_ff    <= 9'd0;
         crc_ff        <= CRC_INIT;
         unit_ff       <= 8'd0;
         crc_low_ff    <= 8'd0;
      end else if (accept) begin
         if (done) begin
            byte_count_ff <= 9'd0;
            exp_len_ff    <= 9'd0;
            crc_ff        <= CRC_INIT;
            unit_ff       <= 8'd0;
            crc_low_ff    <= 8'd0;
         end else begin
            byte_count_ff <= byte_count_in;
            exp_len_ff    <= exp_len_in;
            crc_ff        <= crc_in;
            unit_ff       <= unit_in;
            crc_low_ff    <= crc_low_in;
         end
      end
   end

   // Result valid: set on accept, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff       <= b;
         pos_ff        <= byte_count_ff[7:0];
         pdu_ff        <= pdu_in;
         status_ff     <= status_in;
         frame_unit_ff <= frame_unit_in;
         pdu_len_ff    <= pdu_len_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_data_byte     = data_ff;
   assign rsp_byte_position = pos_ff;
   assign rsp_is_pdu_byte   = pdu_ff;
   assign rsp_frame_status  = status_ff;
   assign rsp_frame_unit    = frame_unit_ff;
   assign rsp_pdu_length    = pdu_len_ff;

   // Checks
   `ASSERT_IMPLIES(a_stall_needs_word, clock, reset, req_stall, rsp_valid_ff)
   `ASSERT_NEXT(a_rearm_after_frame, clock, reset, accept && done,
      byte_count_ff == 9'd0 && exp_len_ff == 9'd0 && crc_ff == CRC_INIT)
   `ASSERT_IMPLIES(a_good_len_matches_pos, clock, reset,
      rsp_valid_ff && status_ff == STATUS_GOOD,
      pos_ff == pdu_len_ff + 8'd2 && !pdu_ff)
   `ASSERT_IMPLIES(a_extras_zero_unless_good, clock, reset,
      rsp_valid_ff && status_ff != STATUS_GOOD,
      frame_unit_ff == 8'd0 && pdu_len_ff == 8'd0)
   `ASSERT_IMPLIES(a_length_within_max, clock, reset, 1'b1,
      exp_len_ff <= 9'(MAX_FRAME_LEN))

endmodule
